### sv/ipv4ap_pkg.sv
// Shared types and character constants for the IPv4 text address parser.
package ipv4ap_pkg;

  // Parse phase of the current part
  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_SKIP
  } phase_t;

  // Number base of the current part
  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  // One character beat handed from the input stage to the parser
  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
  } beat_t;

  // One result handed from the parser to the output stage
  typedef struct packed {
    logic        vld;
    logic [31:0] address;
    logic        valid_res;
  } res_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  // Offsets that map a hex letter onto its value 10..15
  localparam logic [7:0] LO_HEX_OFS = 8'h57;
  localparam logic [7:0] UP_HEX_OFS = 8'h37;

  localparam logic [1:0] LAST_PART = 2'd3;

endpackage

### sv/ipv4_text_address_parser.sv
// Top level of the dotted IPv4 text address parser.
//
// Input channel: one character per beat on in_char_code, taken when in_valid
// is high and in_stall is low. A NUL character ends each string.
// Result channel: one beat per NUL on out_address and out_valid_res, taken
// when out_valid is high and out_stall is low. Other characters give no beat.
// An invalid string gives address 0 with out_valid_res low.
// Path: a NUL is held in the input register, then parsed combinationally,
// and its result is loaded into the output register that drives out_valid.
// Throughput: one character per cycle while in_stall is low; the
// per-character update (shift-add by the base plus range checks) fits
// between the input register and the parse state registers.
// Stall: while a result waits in the output register, non-NUL characters
// keep flowing; a NUL waits in the input register and in_stall rises only
// then.
// Reset: synchronous, active low; clears all parse state so the next
// character starts a new string, and empties both registers.
module ipv4_text_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_address,
  output logic        out_valid_res
);
  import ipv4ap_pkg::*;

  beat_t beat;
  res_t  res;
  logic  can_take;

  ipv4ap_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .can_take     (can_take),
    .beat         (beat)
  );

  ipv4ap_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (beat),
    .res   (res)
  );

  ipv4ap_out_stage u_out_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .can_take      (can_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_address   (out_address),
    .out_valid_res (out_valid_res)
  );

endmodule

### sv/ipv4ap_in_stage.sv
// Input register for character beats, with stall toward the sender.
module ipv4ap_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_code,
  input  logic                 can_take,
  output ipv4ap_pkg::beat_t    beat
);
  import ipv4ap_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       advance;

  // Only a NUL makes a result, so only a NUL waits on the output register
  assign advance  = s1_valid_r && ((s1_char_r != CH_NUL) || can_take);
  assign in_stall = s1_valid_r && !advance;

  assign beat.vld = advance;
  assign beat.ch  = s1_char_r;

  // Load a new beat whenever the held one moves on or the stage is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char_r <= in_char_code;
    end
  end

endmodule

### sv/ipv4ap_parse.sv
// Per-character parse state and next-state logic; emits a result on NUL.
module ipv4ap_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  ipv4ap_pkg::beat_t  beat,
  output ipv4ap_pkg::res_t   res
);
  import ipv4ap_pkg::*;

  phase_t      phase_r, phase_nxt;
  radix_t      radix_r, radix_nxt;
  logic [31:0] part_r, part_nxt;
  logic [7:0]  ep_r   [3];
  logic [7:0]  ep_nxt [3];
  logic [2:0]  big_r, big_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        dv_r, dv_nxt;
  logic [31:0] da_r, da_nxt;

  logic [7:0]  c;
  logic        is_dec, is_space, is_lo_hex, is_up_hex, is_digit;
  logic [3:0]  digit_val;
  logic [31:0] scaled;
  logic        settle_ok;
  logic [31:0] settle_addr;
  logic        run_digits;

  assign c = beat.ch;

  // Classify the character
  always_comb begin
    is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    is_lo_hex = (radix_r == RX_HEX) && (c >= CH_LO_A) && (c <= CH_LO_F);
    is_up_hex = (radix_r == RX_HEX) && (c >= CH_UP_A) && (c <= CH_UP_F);
    is_digit  = is_dec || is_lo_hex || is_up_hex;
    priority if (is_dec) begin
      digit_val = 4'(c - CH_ZERO);
    end else if (is_lo_hex) begin
      digit_val = 4'(c - LO_HEX_OFS);
    end else begin
      digit_val = 4'(c - UP_HEX_OFS);
    end
  end

  // Scale the running part by its base with shifts, plus one add for base 10
  always_comb begin
    unique case (radix_r)
      RX_HEX:  scaled = {part_r[27:0], 4'b0};
      RX_OCT:  scaled = {part_r[28:0], 3'b0};
      default: scaled = {part_r[28:0], 3'b0} + {part_r[30:0], 1'b0};
    endcase
  end

  // Range check each part and assemble the address
  always_comb begin
    unique case (seen_r)
      2'd0: begin
        settle_ok   = 1'b1;
        settle_addr = part_r;
      end
      2'd1: begin
        settle_ok   = !(|part_r[31:24]) && !big_r[0];
        settle_addr = {ep_r[0], part_r[23:0]};
      end
      2'd2: begin
        settle_ok   = !(|part_r[31:16]) && !big_r[0] && !big_r[1];
        settle_addr = {ep_r[0], ep_r[1], part_r[15:0]};
      end
      default: begin
        settle_ok   = !(|part_r[31:8]) && !(|big_r);
        settle_addr = {ep_r[0], ep_r[1], ep_r[2], part_r[7:0]};
      end
    endcase
    settle_ok = settle_ok && ((c == CH_NUL) || is_space);
  end

  // Next state and result
  always_comb begin
    phase_nxt  = phase_r;
    radix_nxt  = radix_r;
    part_nxt   = part_r;
    ep_nxt     = ep_r;
    big_nxt    = big_r;
    seen_nxt   = seen_r;
    dv_nxt     = dv_r;
    da_nxt     = da_r;
    run_digits = 1'b0;
    res        = '0;

    if (beat.vld) begin
      unique case (phase_r)
        PH_START: begin
          if (!is_dec) begin
            dv_nxt    = 1'b0;
            da_nxt    = '0;
            phase_nxt = PH_SKIP;
          end else if (c == CH_ZERO) begin
            part_nxt  = '0;
            radix_nxt = RX_OCT;
            phase_nxt = PH_ZERO;
          end else begin
            part_nxt  = {28'b0, digit_val};
            radix_nxt = RX_DEC;
            phase_nxt = PH_DIGITS;
          end
        end
        PH_ZERO: begin
          phase_nxt = PH_DIGITS;
          if ((c == CH_LO_X) || (c == CH_UP_X)) begin
            radix_nxt = RX_HEX;
          end else begin
            run_digits = 1'b1;
          end
        end
        PH_DIGITS: run_digits = 1'b1;
        default: ;
      endcase

      // Digit, dot or terminating character inside a part
      if (run_digits) begin
        priority if (is_digit) begin
          part_nxt = scaled + {28'b0, digit_val};
        end else if (c == CH_DOT) begin
          if (seen_r == LAST_PART) begin
            dv_nxt    = 1'b0;
            da_nxt    = '0;
            phase_nxt = PH_SKIP;
          end else begin
            ep_nxt[seen_r]  = part_r[7:0];
            big_nxt[seen_r] = |part_r[31:8];
            seen_nxt        = seen_r + 2'd1;
            part_nxt        = '0;
            radix_nxt       = RX_DEC;
            phase_nxt       = PH_START;
          end
        end else begin
          dv_nxt    = settle_ok;
          da_nxt    = settle_ok ? settle_addr : '0;
          phase_nxt = PH_SKIP;
        end
      end

      // Emit on NUL and clear for the next string
      if (c == CH_NUL) begin
        res.vld       = 1'b1;
        res.address   = dv_nxt ? da_nxt : '0;
        res.valid_res = dv_nxt;
        phase_nxt     = PH_START;
        radix_nxt     = RX_DEC;
        part_nxt      = '0;
        ep_nxt        = '{default: '0};
        big_nxt       = '0;
        seen_nxt      = '0;
        dv_nxt        = 1'b0;
        da_nxt        = '0;
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RX_DEC;
      part_r  <= '0;
      ep_r    <= '{default: '0};
      big_r   <= '0;
      seen_r  <= '0;
      dv_r    <= 1'b0;
      da_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      part_r  <= part_nxt;
      ep_r    <= ep_nxt;
      big_r   <= big_nxt;
      seen_r  <= seen_nxt;
      dv_r    <= dv_nxt;
      da_r    <= da_nxt;
    end
  end

endmodule

### sv/ipv4ap_out_stage.sv
// Result register toward the receiver.
module ipv4ap_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  ipv4ap_pkg::res_t  res,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_address,
  output logic              out_valid_res
);
  import ipv4ap_pkg::*;

  logic        out_valid_r;
  logic [31:0] out_address_r;
  logic        out_valid_res_r;

  assign can_take      = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_address   = out_address_r;
  assign out_valid_res = out_valid_res_r;

  // Load a new result or drop the one taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_address_r   <= res.address;
      out_valid_res_r <= res.valid_res;
    end
  end

endmodule

### sv/ipv4ap_checker.sv
// Port-level checks for the IPv4 text address parser and their binding.
module ipv4ap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_address,
  input logic        out_valid_res
);
  import ipv4ap_pkg::*;

  // A failed parse always reports a zero address
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_address == '0)
    else $error("invalid result with nonzero address");

  // The input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // A fresh result follows a NUL beat taken at the input port
  a_nul_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_char_code == CH_NUL), 2))
    else $error("result without a NUL beat");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_address) && $stable(out_valid_res))
    else $error("stalled result changed");

endmodule

bind ipv4_text_address_parser ipv4ap_checker u_ipv4ap_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_char_code  (in_char_code),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_address   (out_address),
  .out_valid_res (out_valid_res)
);
